// ===== rtl/chb_pkg.sv =====
// Shared constants, sizes and item codes for the color histogram builder.
// No dependencies; every rtl file refers to it by scoped names.
package chb_pkg;

  localparam int BINS_PER_CHANNEL = 8;
  localparam int COUNT_BITS       = 20;

  localparam int CH_W        = 8;
  localparam int BIN_W       = $clog2(BINS_PER_CHANNEL);
  localparam int CHROMA_BINS = BINS_PER_CHANNEL * BINS_PER_CHANNEL;
  localparam int NUM_BINS    = CHROMA_BINS * BINS_PER_CHANNEL;
  localparam int IDX_W       = $clog2(NUM_BINS);

  localparam int SEL_W     = 9;
  localparam int OUT_CNT_W = 20;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = FRAC_BITS + 1;
  localparam int SAT_W     = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;
  localparam int STEP_W    = $clog2(FRAC_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [OUT_CNT_W-1:0]  OUT_COUNT_MAX = '1;
  localparam logic [FRAC_W-1:0]     FRAC_ONE      = FRAC_W'(1) << FRAC_BITS;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_HIST_MODE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

endpackage

// ===== rtl/chb_bin_index.sv =====
// Bin address of one pixel: cube binning or chromaticity binning.
// Depends on chb_pkg; purely combinational.
module chb_bin_index (
  input  logic                        mode,
  input  logic [chb_pkg::CH_W-1:0]    chan0,
  input  logic [chb_pkg::CH_W-1:0]    chan1,
  input  logic [chb_pkg::CH_W-1:0]    chan2,
  output logic [chb_pkg::IDX_W-1:0]   idx
);

  localparam int PROD_W = chb_pkg::CH_W + $clog2(chb_pkg::BINS_PER_CHANNEL + 1);
  localparam int SUM_W  = chb_pkg::CH_W + 2;
  localparam int DIV_W  = PROD_W + SUM_W;

  function automatic logic [chb_pkg::BIN_W-1:0] cube_bin(
    input logic [chb_pkg::CH_W-1:0] c
  );
    logic [PROD_W-1:0] p;
    p = PROD_W'(c) * PROD_W'(chb_pkg::BINS_PER_CHANNEL);
    return p[chb_pkg::CH_W +: chb_pkg::BIN_W];
  endfunction

  // restoring long division; the quotient is known to stay below BINS_PER_CHANNEL
  function automatic logic [chb_pkg::BIN_W-1:0] chroma_bin(
    input logic [chb_pkg::CH_W-1:0] c,
    input logic [SUM_W-1:0]         d
  );
    logic [DIV_W-1:0]          r;
    logic [DIV_W-1:0]          ds;
    logic [chb_pkg::BIN_W-1:0] q;
    r = DIV_W'(c) * DIV_W'(chb_pkg::BINS_PER_CHANNEL);
    q = '0;
    for (int i = chb_pkg::BIN_W - 1; i >= 0; i--) begin
      ds = DIV_W'(d) << i;
      if (r >= ds) begin
        r    = r - ds;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  logic [SUM_W-1:0]          sum;
  logic [chb_pkg::BIN_W-1:0] b0;
  logic [chb_pkg::BIN_W-1:0] b1;
  logic [chb_pkg::BIN_W-1:0] b2;

  always_comb begin
    sum = SUM_W'(chan0) + SUM_W'(chan1) + SUM_W'(chan2) + SUM_W'(1);
    if (mode) begin
      b0  = chroma_bin(chan0, sum);
      b1  = chroma_bin(chan1, sum);
      b2  = '0;
      idx = chb_pkg::IDX_W'(b0) * chb_pkg::IDX_W'(chb_pkg::BINS_PER_CHANNEL)
          + chb_pkg::IDX_W'(b1);
    end else begin
      b0  = cube_bin(chan0);
      b1  = cube_bin(chan1);
      b2  = cube_bin(chan2);
      idx = chb_pkg::IDX_W'(b0) * chb_pkg::IDX_W'(chb_pkg::CHROMA_BINS)
          + chb_pkg::IDX_W'(b1) * chb_pkg::IDX_W'(chb_pkg::BINS_PER_CHANNEL)
          + chb_pkg::IDX_W'(b2);
    end
  end

endmodule

// ===== rtl/chb_frac_div.sv =====
// Bit-serial divider for the bin share: floor(count * 2^16 / total), one bit a cycle.
// Gives 2^16 when count >= total and zero when total is zero. Depends on chb_pkg.
module chb_frac_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [chb_pkg::COUNT_BITS-1:0]  count,
  input  logic [chb_pkg::COUNT_BITS-1:0]  total,
  output logic                            done,
  output logic [chb_pkg::FRAC_W-1:0]      frac
);

  typedef enum logic {
    DV_IDLE,
    DV_RUN
  } dv_state_t;

  dv_state_t                          state;
  logic [chb_pkg::COUNT_BITS-1:0]     rem;
  logic [chb_pkg::COUNT_BITS-1:0]     dvsr;
  logic [chb_pkg::FRAC_BITS-1:0]      quo;
  logic [chb_pkg::STEP_W-1:0]         steps;

  logic [chb_pkg::COUNT_BITS:0]       rem_sh;
  logic [chb_pkg::COUNT_BITS:0]       rem_sub;
  logic                               ge;
  logic [chb_pkg::COUNT_BITS-1:0]     rem_next;
  logic [chb_pkg::FRAC_BITS-1:0]      quo_next;

  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_sub  = rem_sh - {1'b0, dvsr};
    ge       = rem_sh >= {1'b0, dvsr};
    rem_next = ge ? rem_sub[chb_pkg::COUNT_BITS-1:0] : rem_sh[chb_pkg::COUNT_BITS-1:0];
    quo_next = {quo[chb_pkg::FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        DV_IDLE: begin
          if (start) begin
            rem   <= count;
            dvsr  <= total;
            quo   <= '0;
            steps <= chb_pkg::STEP_W'(chb_pkg::FRAC_BITS);
            priority if (total == '0) begin
              frac <= '0;
              done <= 1'b1;
            end else if (count >= total) begin
              frac <= chb_pkg::FRAC_ONE;
              done <= 1'b1;
            end else begin
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem   <= rem_next;
          quo   <= quo_next;
          steps <= steps - chb_pkg::STEP_W'(1);
          if (steps == chb_pkg::STEP_W'(1)) begin
            frac  <= chb_pkg::FRAC_W'(quo_next);
            done  <= 1'b1;
            state <= DV_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/color_histogram_builder.sv =====
// Top level of the color histogram builder: command port, bin memory, read sequencer.
// Depends on chb_pkg, chb_bin_index and chb_frac_div.
//
// Pixel items are taken one per cycle while busy is low: each goes through
// a two-stage read-modify-write pipe on the 512 x 20-bit bin memory, with the
// last write forwarded so back-to-back pixels in the same bin count correctly.
// A read item holds busy until its result: it passes the pipe, then the share
// divider, which finishes at once when no pixels are counted or the bin holds
// every pixel, and otherwise runs the 16 steps of its bit-serial division.
// A clear item, and reset, sweep the bin memory one entry a cycle, pausing for
// each pixel still in the pipe; busy stays high until all NUM_BINS (512) are done.
// Configuration writes are taken at any time. The result is shown for one
// cycle only and must be captured then.
module color_histogram_builder (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chb_pkg::ADDR_W-1:0]    paddr,
  input  logic [chb_pkg::DATA_W-1:0]    pwdata,
  output logic [chb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,

  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [chb_pkg::CH_W-1:0]      chan0,
  input  logic [chb_pkg::CH_W-1:0]      chan1,
  input  logic [chb_pkg::CH_W-1:0]      chan2,
  input  logic [chb_pkg::SEL_W-1:0]     bin_select,

  output logic                          done,
  output logic [chb_pkg::OUT_CNT_W-1:0] bin_count,
  output logic [chb_pkg::FRAC_W-1:0]    bin_fraction
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_DIV
  } state_t;

  state_t                           state;
  logic                             hist_mode;
  logic [chb_pkg::COUNT_BITS-1:0]   total;
  logic [chb_pkg::IDX_W-1:0]        clr_addr;

  chb_pkg::func_t                   fn;
  logic                             accept;
  logic                             sel_ok;
  logic [chb_pkg::IDX_W-1:0]        pixel_idx;

  logic                             p1_valid;
  logic                             p1_read;
  logic                             p1_ok;
  logic [chb_pkg::IDX_W-1:0]        p1_addr;
  logic                             p2_valid;
  logic                             p2_read;
  logic                             p2_ok;
  logic [chb_pkg::IDX_W-1:0]        p2_addr;

  logic [chb_pkg::COUNT_BITS-1:0]   mem [chb_pkg::NUM_BINS];
  logic [chb_pkg::COUNT_BITS-1:0]   rdata;
  logic                             pix_we;
  logic                             clr_we;
  logic                             wr_en;
  logic [chb_pkg::IDX_W-1:0]        wr_addr;
  logic [chb_pkg::COUNT_BITS-1:0]   wr_data;
  logic                             last_valid;
  logic [chb_pkg::IDX_W-1:0]        last_addr;
  logic [chb_pkg::COUNT_BITS-1:0]   last_data;
  logic [chb_pkg::COUNT_BITS-1:0]   fwd;
  logic [chb_pkg::COUNT_BITS-1:0]   inc;

  logic                             div_start;
  logic                             div_done;
  logic [chb_pkg::FRAC_W-1:0]       div_frac;
  logic [chb_pkg::COUNT_BITS-1:0]   read_count;
  logic [chb_pkg::COUNT_BITS-1:0]   cnt_hold;
  logic [chb_pkg::SAT_W-1:0]        cnt_ext;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == chb_pkg::REG_HIST_MODE)
                ? chb_pkg::DATA_W'(hist_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == chb_pkg::REG_HIST_MODE) begin
      hist_mode <= pwdata[0];
    end
  end

  // command side
  assign fn     = chb_pkg::func_t'(func);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign sel_ok = 32'(bin_select) < (hist_mode ? chb_pkg::CHROMA_BINS : chb_pkg::NUM_BINS);

  chb_bin_index u_index (
    .mode  (hist_mode),
    .chan0 (chan0),
    .chan1 (chan1),
    .chan2 (chan2),
    .idx   (pixel_idx)
  );

  // read-modify-write pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= accept && (fn == chb_pkg::FUNC_PIXEL || fn == chb_pkg::FUNC_READ);
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    p1_read <= (fn == chb_pkg::FUNC_READ);
    p1_ok   <= sel_ok;
    p1_addr <= (fn == chb_pkg::FUNC_READ) ? chb_pkg::IDX_W'(bin_select) : pixel_idx;
    p2_read <= p1_read;
    p2_ok   <= p1_ok;
    p2_addr <= p1_addr;
  end

  assign pix_we  = p2_valid && !p2_read;
  assign clr_we  = (state == ST_CLEAR) && !pix_we;
  assign wr_en   = pix_we || clr_we;
  assign wr_addr = pix_we ? p2_addr : clr_addr;
  assign fwd     = (last_valid && last_addr == p2_addr) ? last_data : rdata;
  assign inc     = (fwd != chb_pkg::COUNT_MAX) ? fwd + chb_pkg::COUNT_BITS'(1) : fwd;
  assign wr_data = pix_we ? inc : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[p1_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
    end else begin
      last_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    last_addr <= wr_addr;
    last_data <= wr_data;
  end

  // read sequencing
  assign read_count = p2_ok ? fwd : '0;
  assign div_start  = (state == ST_READ) && p2_valid && p2_read;
  assign cnt_ext    = chb_pkg::SAT_W'(cnt_hold);

  chb_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .count (read_count),
    .total (total),
    .done  (div_done),
    .frac  (div_frac)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      cnt_hold <= read_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      total    <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (fn)
              chb_pkg::FUNC_PIXEL: begin
                if (total != chb_pkg::COUNT_MAX) begin
                  total <= total + chb_pkg::COUNT_BITS'(1);
                end
              end
              chb_pkg::FUNC_READ: begin
                state <= ST_READ;
              end
              chb_pkg::FUNC_CLEAR: begin
                state    <= ST_CLEAR;
                clr_addr <= '0;
                total    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (clr_we) begin
            if (clr_addr == chb_pkg::IDX_W'(chb_pkg::NUM_BINS - 1)) begin
              state <= ST_IDLE;
            end else begin
              clr_addr <= clr_addr + chb_pkg::IDX_W'(1);
            end
          end
        end
        ST_READ: begin
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            done         <= 1'b1;
            bin_fraction <= div_frac;
            bin_count    <= (cnt_ext > chb_pkg::SAT_W'(chb_pkg::OUT_COUNT_MAX))
                          ? chb_pkg::OUT_COUNT_MAX : cnt_ext[chb_pkg::OUT_CNT_W-1:0];
            state        <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // checks
  a_done_from_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DIV)
    else $error("result strobe without a finished division");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> bin_fraction <= chb_pkg::FRAC_ONE)
    else $error("bin share above one");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
    accept && fn == chb_pkg::FUNC_CLEAR |=> state == ST_CLEAR && total == '0)
    else $error("clear item did not start the sweep");

  a_read_in_pipe: assert property (@(posedge clk) disable iff (rst)
    p2_valid && p2_read |-> state == ST_READ)
    else $error("read beat left the pipe outside the read state");

endmodule

// ===== dv/tb_color_histogram_builder.sv =====
// Self-checking bench for color_histogram_builder: drives pixel, read, clear and unused commands
// and checks every bin read against a bit-accurate histogram predictor kept in step with the APB mode.
// Depends on rtl/chb_pkg.sv and rtl/color_histogram_builder.sv.
`timescale 1ns / 100ps

module tb_color_histogram_builder;
  import chb_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         REG_SPARE_IDX = 1;
  localparam int         LIMIT         = 4_000_000;

  typedef struct packed {
    logic [1:0]       fn;
    logic [CH_W-1:0]  c0;
    logic [CH_W-1:0]  c1;
    logic [CH_W-1:0]  c2;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] cnt;
    logic [FRAC_W-1:0]    frac;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            func = '0;
  logic [CH_W-1:0]       chan0 = '0;
  logic [CH_W-1:0]       chan1 = '0;
  logic [CH_W-1:0]       chan2 = '0;
  logic [SEL_W-1:0]      bin_select = '0;
  logic                  done;
  logic [OUT_CNT_W-1:0]  bin_count;
  logic [FRAC_W-1:0]     bin_fraction;

  color_histogram_builder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .func(func), .chan0(chan0), .chan1(chan1), .chan2(chan2),
    .bin_select(bin_select),
    .done(done), .bin_count(bin_count), .bin_fraction(bin_fraction)
  );

  always #5 clk = ~clk;

  // histogram shadow
  logic [COUNT_BITS-1:0] bin_hist [NUM_BINS] = '{default: '0};
  logic [COUNT_BITS-1:0] pix_total = '0;
  logic                  mode_shadow = 1'b0;

  cmd_t   cmd_q[$];
  reply_t reply_q[$];
  cmd_t   cur_cmd = '0;

  int unsigned n_pushed = 0, n_accepted = 0, n_err = 0, n_cycles = 0;
  int unsigned n_pixels = 0, n_reads = 0, n_clears = 0, n_unused = 0, n_writes = 0;
  int unsigned burst_left = 1, gap_left = 0;
  bit          gaps_off = 1'b0;

  int unsigned     hit_bins [16] = '{default: 0};
  int unsigned     hit_wr = 0;
  logic [23:0]     palette [4];

  function automatic int unsigned pixel_bin(logic m, logic [CH_W-1:0] a, b, c);
    int unsigned s, i0, i1, i2;
    if (m) begin
      s  = int'(a) + int'(b) + int'(c);
      i0 = (BINS_PER_CHANNEL * int'(a)) / (s + 1);
      i1 = (BINS_PER_CHANNEL * int'(b)) / (s + 1);
      return i0 * BINS_PER_CHANNEL + i1;
    end
    i0 = (int'(a) * BINS_PER_CHANNEL) >> CH_W;
    i1 = (int'(b) * BINS_PER_CHANNEL) >> CH_W;
    i2 = (int'(c) * BINS_PER_CHANNEL) >> CH_W;
    return i0 * CHROMA_BINS + i1 * BINS_PER_CHANNEL + i2;
  endfunction

  task automatic histogram_step(input cmd_t c);
    int unsigned           b, lim;
    logic [COUNT_BITS-1:0] cnt;
    longint unsigned       q;
    reply_t                r;
    case (c.fn)
      FUNC_PIXEL: begin
        n_pixels++;
        b = pixel_bin(mode_shadow, c.c0, c.c1, c.c2);
        if (b < NUM_BINS && bin_hist[b] != COUNT_MAX) bin_hist[b]++;
        if (pix_total != COUNT_MAX) pix_total++;
      end
      FUNC_READ: begin
        n_reads++;
        lim = mode_shadow ? CHROMA_BINS : NUM_BINS;
        cnt = (c.sel < lim) ? bin_hist[c.sel] : '0;
        q   = 0;
        if (pix_total != '0) begin
          q = (64'(cnt) << FRAC_BITS) / 64'(pix_total);
          if (q > FRAC_ONE) q = FRAC_ONE;
        end
        r.cnt  = (cnt > OUT_COUNT_MAX) ? OUT_COUNT_MAX : OUT_CNT_W'(cnt);
        r.frac = FRAC_W'(q);
        reply_q = {reply_q, r};
      end
      FUNC_CLEAR: begin
        n_clears++;
        foreach (bin_hist[i]) bin_hist[i] = '0;
        pix_total = '0;
      end
      default: n_unused++;
    endcase
  endtask

  // command driver: hold the beat until busy drops, then advance
  always @(posedge clk) begin : cmd_driver
    bit go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        histogram_step(cur_cmd);
        n_accepted++;
      end
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left != 0 && !gaps_off) begin
        gap_left--;
      end else if (cmd_q.size() != 0) begin
        cur_cmd = cmd_q.pop_front();
        go = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(6, 24);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end
      end
      start      <= go;
      func       <= cur_cmd.fn;
      chan0      <= cur_cmd.c0;
      chan1      <= cur_cmd.c1;
      chan2      <= cur_cmd.c2;
      bin_select <= cur_cmd.sel;
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    reply_t want;
    if (!rst && done) begin
      if (reply_q.size() == 0) begin
        $error("result with nothing pending: bin_count %0d bin_fraction %0d",
               bin_count, bin_fraction);
        n_err++;
      end else begin
        want = reply_q.pop_front();
        if (bin_count !== want.cnt) begin
          $error("bin_count expected %0d actual %0d", want.cnt, bin_count);
          n_err++;
        end
        if (bin_fraction !== want.frac) begin
          $error("bin_fraction expected %0d actual %0d", want.frac, bin_fraction);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d commands taken",
               n_cycles, n_accepted, n_pushed);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_cmd(input logic [1:0] fn, input logic [CH_W-1:0] a, b, c,
                          input logic [SEL_W-1:0] s);
    cmd_t x;
    x.fn = fn; x.c0 = a; x.c1 = b; x.c2 = c; x.sel = s;
    cmd_q = {cmd_q, x};
    n_pushed++;
  endtask

  task automatic push_pixel(input logic [CH_W-1:0] a, b, c);
    hit_bins[hit_wr] = pixel_bin(mode_shadow, a, b, c);
    hit_wr = (hit_wr + 1) % 16;
    push_cmd(FUNC_PIXEL, a, b, c, SEL_W'($urandom));
  endtask

  task automatic push_read(input logic [SEL_W-1:0] s);
    push_cmd(FUNC_READ, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), s);
  endtask

  task automatic push_clear();
    push_cmd(FUNC_CLEAR, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), SEL_W'($urandom));
  endtask

  task automatic push_random();
    int unsigned k;
    logic [23:0] p;
    k = $urandom_range(0, 99);
    if (k < 58) begin
      case ($urandom_range(0, 9))
        0, 1: push_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        2: push_pixel($urandom_range(0, 1) ? 8'hFF : 8'h00, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                      $urandom_range(0, 1) ? 8'hFF : 8'h00);
        default: begin
          p = palette[$urandom_range(0, 3)];
          push_pixel(p[23:16] ^ CH_W'($urandom_range(0, 15)), p[15:8] ^ CH_W'($urandom_range(0, 15)),
                     p[7:0] ^ CH_W'($urandom_range(0, 15)));
        end
      endcase
    end else if (k < 92) begin
      case ($urandom_range(0, 9))
        6, 7:    push_read(SEL_W'($urandom_range(0, mode_shadow ? CHROMA_BINS - 1 : NUM_BINS - 1)));
        8:       push_read(SEL_W'($urandom_range(0, NUM_BINS - 1)));
        9: begin
          case ($urandom_range(0, 3))
            0:       push_read(SEL_W'(0));
            1:       push_read(SEL_W'(CHROMA_BINS - 1));
            2:       push_read(SEL_W'(CHROMA_BINS));
            default: push_read(SEL_W'(NUM_BINS - 1));
          endcase
        end
        default: push_read(SEL_W'(hit_bins[$urandom_range(0, 15)]));
      endcase
    end else if (k < 97) begin
      push_cmd(FUNC_UNUSED, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), SEL_W'($urandom));
    end else begin
      push_clear();
    end
  endtask

  task automatic wait_quiet();
    while (n_accepted != n_pushed || reply_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(input int unsigned idx, input logic [DATA_W-1:0] d);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_W'(4 * idx); pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_HIST_MODE) mode_shadow = d[0];
    n_writes++;
  endtask

  task automatic reg_check();
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_W'(4 * REG_HIST_MODE);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(mode_shadow)) begin
      $error("hist_mode expected %0d actual %0d", mode_shadow, prdata);
      n_err++;
    end
    psel <= 1'b0; penable <= 1'b0;
  endtask

  initial begin
    logic        m;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);

    // cube mode from reset: empty histogram, corners, unused code, clear
    push_read(SEL_W'(0));
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'h00, 8'h80);
    push_read(SEL_W'(0));
    push_read(SEL_W'(NUM_BINS - 1));
    push_cmd(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, '1);
    push_read(SEL_W'(NUM_BINS - 1));
    push_clear();
    push_read(SEL_W'(NUM_BINS - 1));
    push_pixel(8'h80, 8'h40, 8'h20);
    push_read(SEL_W'(pixel_bin(1'b0, 8'h80, 8'h40, 8'h20)));
    wait_quiet();

    // chromaticity: bins past 63 read as empty, the store is kept
    reg_write(REG_HIST_MODE, 32'hFFFF_FFFF);
    reg_check();
    push_read(SEL_W'(pixel_bin(1'b0, 8'h80, 8'h40, 8'h20)));
    push_pixel(8'h00, 8'h00, 8'h00);
    push_pixel(8'hFF, 8'hFF, 8'hFF);
    push_pixel(8'hFF, 8'h00, 8'h00);
    push_pixel(8'h00, 8'hFF, 8'h00);
    push_read(SEL_W'(56));
    push_read(SEL_W'(CHROMA_BINS - 1));
    push_read(SEL_W'(CHROMA_BINS));
    push_read(SEL_W'(7));
    wait_quiet();

    reg_write(REG_SPARE_IDX, 32'h1);
    reg_write(REG_HIST_MODE, 32'hFFFF_FFFE);
    reg_check();
    push_read(SEL_W'(0));
    push_read(SEL_W'(18));
    push_read(SEL_W'(pixel_bin(1'b0, 8'h80, 8'h40, 8'h20)));
    wait_quiet();

    for (int ph = 0; ph < 6; ph++) begin
      m = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      reg_write(REG_HIST_MODE, {$urandom} & 32'hFFFF_FFFE | DATA_W'(m));
      reg_check();
      gaps_off = (ph == 5);
      foreach (palette[i]) palette[i] = 24'($urandom);
      if ($urandom_range(0, 1)) push_clear();
      repeat (285) push_random();
      wait_quiet();
    end
    gaps_off = 1'b0;

    repeat (30) @(posedge clk);
    $display("covered %0d pixels, %0d bin reads, %0d clears, %0d unused commands",
             n_pixels, n_reads, n_clears, n_unused);
    $display("over %0d register writes, switching between cube and chromaticity binning",
             n_writes);
    if (n_err == 0 && reply_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
